FILE: design/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

  // Parse phases of the frame header and payload.
  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_KEY    = 3'd3,
    PH_DATA   = 3'd4
  } phase_t;

  localparam logic [6:0] LEN16_CODE  = 7'd126;
  localparam logic [6:0] LEN64_CODE  = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic [3:0] frame_opcode;
    logic       frame_end;
  } result_t;

endpackage
`default_nettype wire

FILE: design/websocket_frame_deframer.sv
// WebSocket frame deframer: byte-wise RFC 6455 header parser and payload unmasker.
//
// Usage: feed the received stream after the opening handshake, one byte per
// beat, on in_valid / in_stall / in_rx_byte. Each payload byte leaves on the
// result channel, unmasked with the frame's key, together with the frame's
// opcode; the last byte of a frame has out_frame_end set. A frame of zero
// length gives a single beat with out_byte_valid low and out_frame_end high,
// on the byte that completes its header. Header bytes give no result.
// Each result is registered in the output register, or in the skid stage
// while the output holds a beat not yet taken. Throughput: one input byte
// per cycle while in_stall is low, set by the combinational parse and
// unmask step and the one-entry skid stage behind the output register.
// Stalling: while out_stall holds a waiting result, one more result is kept
// in the skid stage; in_stall rises only once that stage is full and falls
// as soon as the receiver takes a beat. Bytes that give no result are taken
// whenever the skid stage is free.
// Reset (rst_n low, synchronous): the parser returns to waiting for the first
// header byte and both output stages are emptied.
`default_nettype none
module websocket_frame_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_payload_byte,
  output logic            out_byte_valid,
  output logic [3:0]      out_frame_opcode,
  output logic            out_frame_end
);

  wsd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_r, mask_nxt;
  logic [3:0]  ext_left_r, ext_left_nxt;
  logic [31:0] key_r, key_nxt;
  logic [2:0]  key_left_r, key_left_nxt;
  logic [31:0] pay_left_r, pay_left_nxt;
  logic [1:0]  key_idx_r, key_idx_nxt;

  wsd_pkg::result_t res;
  logic             res_v;
  wsd_pkg::result_t out_r, skid_r;
  logic             out_valid_r, skid_valid_r;

  logic        accept;
  logic        out_take;
  logic [6:0]  len7;
  logic [31:0] len_shift;
  logic [31:0] pay_dec;
  logic [3:0]  ext_dec;
  logic [2:0]  key_dec;
  logic [7:0]  key_byte;

  assign accept    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign len7      = in_rx_byte[6:0];
  assign len_shift = {pay_left_r[23:0], in_rx_byte};
  assign pay_dec   = pay_left_r - 32'd1;
  assign ext_dec   = ext_left_r - 4'd1;
  assign key_dec   = key_left_r - 3'd1;

  always_comb begin
    case (key_idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      wsd_pkg::PH_HDR1: begin
        if (len7 == wsd_pkg::LEN16_CODE || len7 == wsd_pkg::LEN64_CODE) begin
          phase_nxt = wsd_pkg::PH_EXTLEN;
        end else if (in_rx_byte[7]) begin
          phase_nxt = wsd_pkg::PH_KEY;
        end else if (len7 == 7'd0) begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end else begin
          phase_nxt = wsd_pkg::PH_DATA;
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        if (ext_dec == 4'd0) begin
          if (mask_r) begin
            phase_nxt = wsd_pkg::PH_KEY;
          end else if (len_shift == 32'd0) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end else begin
            phase_nxt = wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_KEY: begin
        if (key_dec == 3'd0) begin
          phase_nxt = (pay_left_r == 32'd0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DATA;
        end
      end
      wsd_pkg::PH_DATA: begin
        if (pay_dec == 32'd0) begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      end
      default: phase_nxt = wsd_pkg::PH_HDR1;
    endcase
  end

  // Header fields, payload unmasking and the result of this byte.
  always_comb begin
    opcode_nxt   = opcode_r;
    mask_nxt     = mask_r;
    ext_left_nxt = ext_left_r;
    key_nxt      = key_r;
    key_left_nxt = key_left_r;
    pay_left_nxt = pay_left_r;
    key_idx_nxt  = key_idx_r;
    res_v        = 1'b0;
    res.payload_byte = 8'd0;
    res.byte_valid   = 1'b0;
    res.frame_opcode = opcode_r;
    res.frame_end    = 1'b1;
    case (phase_r)
      wsd_pkg::PH_HDR1: begin
        mask_nxt     = in_rx_byte[7];
        pay_left_nxt = 32'd0;
        if (len7 == wsd_pkg::LEN16_CODE) begin
          ext_left_nxt = wsd_pkg::EXT16_BYTES;
        end else if (len7 == wsd_pkg::LEN64_CODE) begin
          ext_left_nxt = wsd_pkg::EXT64_BYTES;
        end else begin
          pay_left_nxt = {25'd0, len7};
          if (in_rx_byte[7]) begin
            key_nxt      = 32'd0;
            key_left_nxt = wsd_pkg::KEY_BYTES;
          end else begin
            key_idx_nxt = 2'd0;
            res_v       = (len7 == 7'd0);
          end
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        pay_left_nxt = len_shift;
        ext_left_nxt = ext_dec;
        if (ext_dec == 4'd0) begin
          if (mask_r) begin
            key_nxt      = 32'd0;
            key_left_nxt = wsd_pkg::KEY_BYTES;
          end else begin
            key_idx_nxt = 2'd0;
            res_v       = (len_shift == 32'd0);
          end
        end
      end
      wsd_pkg::PH_KEY: begin
        key_nxt      = {key_r[23:0], in_rx_byte};
        key_left_nxt = key_dec;
        if (key_dec == 3'd0) begin
          key_idx_nxt = 2'd0;
          res_v       = (pay_left_r == 32'd0);
        end
      end
      wsd_pkg::PH_DATA: begin
        key_idx_nxt      = key_idx_r + 2'd1;
        pay_left_nxt     = pay_dec;
        res_v            = 1'b1;
        res.payload_byte = mask_r ? (in_rx_byte ^ key_byte) : in_rx_byte;
        res.byte_valid   = 1'b1;
        res.frame_end    = (pay_dec == 32'd0);
      end
      default: opcode_nxt = in_rx_byte[3:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wsd_pkg::PH_HDR0;
      opcode_r   <= 4'd0;
      mask_r     <= 1'b0;
      ext_left_r <= 4'd0;
      key_r      <= 32'd0;
      key_left_r <= 3'd0;
      pay_left_r <= 32'd0;
      key_idx_r  <= 2'd0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      opcode_r   <= opcode_nxt;
      mask_r     <= mask_nxt;
      ext_left_r <= ext_left_nxt;
      key_r      <= key_nxt;
      key_left_r <= key_left_nxt;
      pay_left_r <= pay_left_nxt;
      key_idx_r  <= key_idx_nxt;
    end
  end

  // Output register with a one-entry skid stage behind it. No new result can
  // arrive while the skid stage is full, as the input is then stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept && res_v) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (accept && res_v) begin
      if (out_valid_r && !out_take) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign in_stall         = skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_r.payload_byte;
  assign out_byte_valid   = out_r.byte_valid;
  assign out_frame_opcode = out_r.frame_opcode;
  assign out_frame_end    = out_r.frame_end;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid stage filled without a stalled output");

  a_data_phase_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wsd_pkg::PH_DATA) |-> (pay_left_r != 32'd0))
    else $error("payload phase entered with no bytes left");

  a_empty_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.byte_valid) |-> out_r.frame_end)
    else $error("empty frame marker without frame end");

endmodule
`default_nettype wire

FILE: dv/websocket_frame_deframer_tb.sv
// Self-checking testbench for the WebSocket frame deframer, with a byte-level predictor.
`timescale 1ns / 100ps
module websocket_frame_deframer_tb;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic       FIN       = 1'b1;
  localparam logic       MASKED    = 1'b1;
  localparam logic       UNMASKED  = 1'b0;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_payload_byte;
  logic       out_byte_valid;
  logic [3:0] out_frame_opcode;
  logic       out_frame_end;

  websocket_frame_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_byte_valid   (out_byte_valid),
    .out_frame_opcode (out_frame_opcode),
    .out_frame_end    (out_frame_end)
  );

  // Predictor state, mirroring the parser inside the block.
  wsd_pkg::phase_t parse_ph;
  logic [3:0]  frame_op;
  logic        frame_masked;
  logic [3:0]  ext_bytes_left;
  logic [31:0] unmask_key;
  logic [2:0]  key_bytes_left;
  logic [31:0] bytes_remaining;
  logic [1:0]  key_pos;

  wsd_pkg::result_t expected_beats[$];
  wsd_pkg::result_t got_beat;
  int          mismatches;
  int unsigned bytes_sent;
  int          send_idle_pct;
  int          recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("websocket_frame_deframer_tb: FAIL");
    $finish;
  end

  // Works out what one accepted byte should produce and queues it.
  task automatic deframe_byte(input logic [7:0] b);
    wsd_pkg::result_t beat;
    logic    emit;
    logic    length_known;
    logic    header_complete;
    emit            = 1'b0;
    length_known    = 1'b0;
    header_complete = 1'b0;
    beat            = '0;
    case (parse_ph)
      wsd_pkg::PH_HDR1: begin
        frame_masked    = b[7];
        bytes_remaining = '0;
        if (b[6:0] == wsd_pkg::LEN16_CODE) begin
          ext_bytes_left = wsd_pkg::EXT16_BYTES;
          parse_ph       = wsd_pkg::PH_EXTLEN;
        end else if (b[6:0] == wsd_pkg::LEN64_CODE) begin
          ext_bytes_left = wsd_pkg::EXT64_BYTES;
          parse_ph       = wsd_pkg::PH_EXTLEN;
        end else begin
          bytes_remaining = {25'd0, b[6:0]};
          length_known    = 1'b1;
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        // Only the low 32 bits of a 64-bit length survive the shifting.
        bytes_remaining = {bytes_remaining[23:0], b};
        ext_bytes_left  = ext_bytes_left - 4'd1;
        length_known    = (ext_bytes_left == 4'd0);
      end
      wsd_pkg::PH_KEY: begin
        unmask_key      = {unmask_key[23:0], b};
        key_bytes_left  = key_bytes_left - 3'd1;
        header_complete = (key_bytes_left == 3'd0);
      end
      wsd_pkg::PH_DATA: begin
        beat.payload_byte = frame_masked ? b ^ unmask_key[8 * (3 - key_pos) +: 8] : b;
        beat.byte_valid   = 1'b1;
        beat.frame_opcode = frame_op;
        key_pos           = key_pos + 2'd1;
        bytes_remaining   = bytes_remaining - 32'd1;
        beat.frame_end    = (bytes_remaining == 32'd0);
        if (bytes_remaining == 32'd0) begin
          parse_ph = wsd_pkg::PH_HDR0;
        end
        emit = 1'b1;
      end
      default: begin
        frame_op = b[3:0];
        parse_ph = wsd_pkg::PH_HDR1;
      end
    endcase
    if (length_known) begin
      if (frame_masked) begin
        unmask_key     = '0;
        key_bytes_left = wsd_pkg::KEY_BYTES;
        parse_ph       = wsd_pkg::PH_KEY;
      end else begin
        header_complete = 1'b1;
      end
    end
    if (header_complete) begin
      key_pos = '0;
      if (bytes_remaining == 32'd0) begin
        // An empty frame still gives one marker beat.
        beat.frame_opcode = frame_op;
        beat.frame_end    = 1'b1;
        parse_ph          = wsd_pkg::PH_HDR0;
        emit              = 1'b1;
      end else begin
        parse_ph = wsd_pkg::PH_DATA;
      end
    end
    if (emit) begin
      expected_beats.push_back(beat);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    // The stall only changes at a rising edge, so it is settled here.
    while (in_stall) @(negedge clk);
    @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] first_byte, input logic masked,
                            input logic [31:0] plen, input len_form_t form);
    logic [31:0] high_word;
    logic [31:0] key_word;
    high_word = $urandom;
    key_word  = $urandom;
    send_byte(first_byte);
    case (form)
      LEN_SHORT: send_byte({masked, plen[6:0]});
      LEN_EXT16: begin
        send_byte({masked, wsd_pkg::LEN16_CODE});
        send_byte(plen[15:8]);
        send_byte(plen[7:0]);
      end
      default: begin
        send_byte({masked, wsd_pkg::LEN64_CODE});
        for (int i = 3; i >= 0; i--) send_byte(high_word[8 * i +: 8]);
        for (int i = 3; i >= 0; i--) send_byte(plen[8 * i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key_word[8 * i +: 8]);
    end
    repeat (plen) send_byte(8'($urandom));
  endtask

  // Holds the sender off until every queued result has been taken.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_frames();
    send_byte({FIN, 3'b000, OP_PING});
    send_byte({UNMASKED, 7'd0});
  endtask

  task automatic test_payload_unmasking();
    send_byte({FIN, 3'b000, OP_TEXT});
    send_byte({MASKED, 7'd1});
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h00);
    // A 16-bit length that would have fitted the short form, unmasked.
    send_byte({FIN, 3'b000, OP_BINARY});
    send_byte({UNMASKED, wsd_pkg::LEN16_CODE});
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
  endtask

  task automatic test_long_lengths();
    // Reserved opcode with the RSV bits set, and a 64-bit length whose
    // low word is zero, so the frame ends up empty after its key.
    send_byte(8'hFF);
    send_byte({MASKED, wsd_pkg::LEN64_CODE});
    repeat (4) send_byte(8'hFF);
    repeat (4) send_byte(8'h00);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h78);
  endtask

  task automatic test_random_stream(input int sender_pct, input int receiver_pct,
                                    input int unsigned byte_budget);
    int unsigned stop_at;
    int unsigned pick;
    logic [31:0] plen;
    len_form_t   form;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    stop_at       = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        form = LEN_SHORT;
        plen = $urandom_range(8);
      end else if (pick < 78) begin
        form = LEN_SHORT;
        plen = $urandom_range(100, 125);
      end else if (pick < 90) begin
        form = LEN_EXT16;
        plen = ($urandom_range(7) == 0) ? $urandom_range(256, 300) : $urandom_range(12);
      end else begin
        form = LEN_EXT64;
        plen = $urandom_range(12);
      end
      send_frame(8'($urandom), 1'($urandom), plen, form);
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = rst_n && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_beat = '{out_payload_byte, out_byte_valid, out_frame_opcode, out_frame_end};
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected beat: byte=%h valid=%b op=%h end=%b",
                   got_beat.payload_byte, got_beat.byte_valid,
                   got_beat.frame_opcode, got_beat.frame_end);
        end
      end else begin
        if (expected_beats[0].payload_byte !== got_beat.payload_byte ||
            expected_beats[0].byte_valid   !== got_beat.byte_valid   ||
            expected_beats[0].frame_opcode !== got_beat.frame_opcode ||
            expected_beats[0].frame_end    !== got_beat.frame_end) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp b=%h v=%b op=%h end=%b got b=%h v=%b op=%h end=%b",
                     expected_beats[0].payload_byte, expected_beats[0].byte_valid,
                     expected_beats[0].frame_opcode, expected_beats[0].frame_end,
                     got_beat.payload_byte, got_beat.byte_valid,
                     got_beat.frame_opcode, got_beat.frame_end);
          end
        end
        void'(expected_beats.pop_front());
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_rx_byte      = 8'h00;
    mismatches      = 0;
    bytes_sent      = 0;
    send_idle_pct   = 21;
    recv_idle_pct   = 81;
    parse_ph        = wsd_pkg::PH_HDR0;
    frame_op        = '0;
    frame_masked    = 1'b0;
    ext_bytes_left  = '0;
    unmask_key      = '0;
    key_bytes_left  = '0;
    bytes_remaining = '0;
    key_pos         = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_frames();
    test_payload_unmasking();
    test_long_lengths();
    test_random_stream(21, 81, 210);
    wait_for_results();
    test_random_stream(81, 21, 210);
    wait_for_results();
    test_random_stream(0, 0, 220);
    wait_for_results();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("websocket_frame_deframer_tb: PASS");
    end else begin
      $display("websocket_frame_deframer_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/wsd_pkg.sv
design/websocket_frame_deframer.sv
dv/websocket_frame_deframer_tb.sv
